>>> hdl/crcfc_pkg.sv
package crcfc_pkg;

	localparam int SLOT_BYTES  = 128;
	localparam int MAX_PAYLOAD = 120;
	localparam int HDR_BYTES   = 8;
	localparam int IDX_W       = $clog2(SLOT_BYTES);
	localparam int CAP_W       = 7;
	localparam int PADDR_W     = 3;

	localparam logic [15:0] CRC_POLY = 16'hAC9A;
	localparam logic [15:0] CRC_SEED = 16'h4657;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// register select, taken from paddr[2]
	localparam logic REG_OUT_CAPACITY   = 1'b0;
	localparam logic REG_PAYLOAD_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CRC       = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_REMOTE    = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       payload_byte;
		status_t          status;
		logic [7:0]       pay_len;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [CAP_W-1:0] out_capacity;
		logic             payload_enable;
	} cfg_t;

	// MSB-first CRC-16, one byte, unrolled
	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

>>> hdl/crcfc_cfg.sv
module crcfc_cfg
	import crcfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [CAP_W-1:0] out_capacity_q;
	logic             payload_enable_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q   <= CAP_W'(MAX_PAYLOAD);
			payload_enable_q <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				REG_OUT_CAPACITY:   out_capacity_q   <= pwdata[CAP_W-1:0];
				REG_PAYLOAD_ENABLE: payload_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OUT_CAPACITY:   prdata = 32'(out_capacity_q);
			REG_PAYLOAD_ENABLE: prdata = 32'(payload_enable_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.out_capacity   = out_capacity_q;
	assign cfg.payload_enable = payload_enable_q;

endmodule

>>> hdl/crcfc_core.sv
module crcfc_core
	import crcfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  cfg_t       cfg,
	input  logic       room,
	output logic [1:0] push_n,
	output result_t    res0,
	output result_t    res1
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             advance;

	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [15:0]      rcrc_q;
	logic             rerr_q;
	logic [7:0]       len_q;

	logic             act;
	logic [IDX_W-1:0] idx_b;
	logic [15:0]      crc_b, crc_n, rcrc_n;
	logic             rerr_n;
	logic [7:0]       len_n;
	logic [8:0]       pay_off;
	logic             in_pay, len_bad, is_final, pay_emit;
	status_t          st;
	result_t          pay_res, st_res;

	assign advance  = valid_s1 & room;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	always_comb begin
		act    = start_s1 | active_q;
		idx_b  = start_s1 ? '0 : idx_q;
		crc_b  = start_s1 ? CRC_SEED : crc_q;
		rcrc_n = start_s1 ? 16'h0000 : rcrc_q;
		rerr_n = start_s1 ? 1'b0 : rerr_q;
		len_n  = start_s1 ? 8'h00 : len_q;
		crc_n  = crc_b;

		pay_off = 9'(idx_b) - 9'(HDR_BYTES);
		in_pay  = (9'(idx_b) >= 9'(HDR_BYTES)) && (pay_off < 9'(len_n));

		if (idx_b < IDX_W'(4)) begin
			if (byte_s1 != 8'h00) rerr_n = 1'b1;
			crc_n = crc_update(crc_b, byte_s1);
		end else if (idx_b < IDX_W'(6)) begin
			if (idx_b == IDX_W'(5)) len_n = byte_s1;
			crc_n = crc_update(crc_b, byte_s1);
		end else if (idx_b < IDX_W'(HDR_BYTES)) begin
			if (idx_b == IDX_W'(6)) begin
				rcrc_n[7:0] = byte_s1;
			end else begin
				rcrc_n[15:8] = byte_s1;
			end
			crc_n = crc_update(crc_b, 8'h00);
		end else if (in_pay) begin
			crc_n = crc_update(crc_b, byte_s1);
		end

		len_bad  = (len_n > 8'(MAX_PAYLOAD)) ||
		           ((10'(len_n) + 10'(HDR_BYTES)) > 10'(SLOT_BYTES));
		is_final = (idx_b == IDX_W'(SLOT_BYTES - 1));
		pay_emit = (9'(idx_b) >= 9'(HDR_BYTES)) && in_pay && cfg.payload_enable && !len_bad;

		if (len_bad) begin
			st = ST_MALFORMED;
		end else if (crc_n != rcrc_n) begin
			st = ST_CRC;
		end else if (rerr_n) begin
			st = ST_REMOTE;
		end else if (cfg.payload_enable && (len_n > 8'(cfg.out_capacity))) begin
			st = ST_TOO_LARGE;
		end else begin
			st = ST_OK;
		end

		pay_res.kind           = KIND_PAYLOAD;
		pay_res.payload_byte   = byte_s1;
		pay_res.status         = ST_OK;
		pay_res.pay_len        = len_n;
		pay_res.last           = 1'b0;

		st_res.kind            = KIND_STATUS;
		st_res.payload_byte    = 8'h00;
		st_res.status          = st;
		st_res.pay_len         = len_n;
		st_res.last            = 1'b1;

		res0   = pay_emit ? pay_res : st_res;
		res1   = st_res;
		push_n = 2'b00;
		if (advance && act) begin
			push_n = 2'(pay_emit) + 2'(is_final);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			crc_q    <= CRC_SEED;
			rcrc_q   <= '0;
			rerr_q   <= 1'b0;
			len_q    <= '0;
		end else if (advance && act) begin
			crc_q  <= crc_n;
			rcrc_q <= rcrc_n;
			rerr_q <= rerr_n;
			len_q  <= len_n;
			if (is_final) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else begin
				active_q <= 1'b1;
				idx_q    <= idx_b + IDX_W'(1);
			end
		end
	end

endmodule

>>> hdl/crcfc_oq.sv
module crcfc_oq
	import crcfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    res0,
	input  result_t    res1,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_res
);

	result_t             mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign room      = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			cnt_q <= cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

endmodule

>>> hdl/crc16_message_frame_checker_unit.sv
// Response slot checker: CRC-16 (MSB first) over header and payload.
// Input stream s_*: one slot byte per request, s_tdata[7:0] = rx_byte,
// s_tuser = frame_start (byte zero of a slot). Bytes outside a slot are dropped.
// Output stream m_*: payload byte results (m_tuser = 0) as they arrive, and
// one status result (m_tuser = 1, m_tlast = 1) after the final slot byte.
// APB registers: 0x0 out_capacity (7 bit), 0x4 payload_enable (1 bit).
// Path: a byte's result passes the input register, then the result queue.
// Throughput: one byte per cycle given queue room; the CRC byte update is
// unrolled between the input register and a 4-entry result queue. The final
// byte may give two results; the queue absorbs that without stopping the input.
// Receiver stall: the queue fills, then s_tready drops once fewer than two
// queue entries are free; nothing is lost.
// Reset: input register and queue empty, no slot active, CRC at its seed,
// out_capacity 120, payload_enable 1.
module crc16_message_frame_checker_unit
	import crcfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	input  logic               s_tuser,   // [0] frame_start
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [7:0] payload_byte, [10:8] status,
	                                      // [18:11] pay_len, [23:19] zero
	output logic               m_tuser,   // [0] kind
	output logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t       cfg;
	logic       room;
	logic [1:0] push_n;
	result_t    res0, res1, out_res;

	crcfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crcfc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.cfg         (cfg),
		.room        (room),
		.push_n      (push_n),
		.res0        (res0),
		.res1        (res1)
	);

	crcfc_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'b00000, out_res.pay_len, out_res.status, out_res.payload_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

`ifndef ASSERT_OFF
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("tlast and status kind disagree");

	a_payload_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_PAYLOAD)) |-> (status_t'(m_tdata[10:8]) == ST_OK))
		else $error("payload result carries a status");

	a_payload_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_PAYLOAD)) |-> (m_tdata[18:11] <= 8'(MAX_PAYLOAD)))
		else $error("payload delivered for malformed length");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_STATUS)) |-> (m_tdata[7:0] == 8'h00))
		else $error("status result carries a payload byte");
`endif

endmodule
